// ----- sv/tss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and sizes of the tiered sorted integer set.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned NARROW_DEPTH = 256;
  localparam int unsigned MIDDLE_DEPTH = 256;
  localparam int unsigned WIDE_DEPTH   = 256;
  localparam int unsigned NUM_TIERS    = 3;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned TOT_W        = 10;
  localparam logic signed [63:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_FIND    = 3'd2,
    OP_GET     = 3'd3,
    OP_RESTART = 3'd4,
    OP_NEXT    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TIER_NARROW = 2'd0,
    TIER_MIDDLE = 2'd1,
    TIER_WIDE   = 2'd2
  } tier_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_HIT_RD, S_HIT_CMP, S_DECIDE,
    S_SHIFT_RD, S_SHIFT_WR, S_MERGE_RD, S_MERGE_CMP, S_OUT
  } state_t;

  // One tier store port: request side.
  typedef struct packed {
    logic              rd;
    logic [IDX_W-1:0]  raddr;
    logic              wr;
    logic [IDX_W-1:0]  waddr;
    logic signed [63:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] value_out;
    logic [TOT_W-1:0]   rank_out;
    logic [TOT_W-1:0]   member_count;
  } result_t;

  function automatic tier_t tier_of(input logic signed [63:0] v);
    if (v >= -64'sd32768 && v <= 64'sd32767) return TIER_NARROW;
    if (v >= -64'sd2147483648 && v <= 64'sd2147483647) return TIER_MIDDLE;
    return TIER_WIDE;
  endfunction

endpackage

// ----- sv/tss_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_in_if / tss_out_if
// Valid/ready channels for operations and results.
// ----------------------------------------------------------------------------
interface tss_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [63:0] key;
  logic [9:0]         rank;
  modport source (output valid, operation, key, rank, input ready);
  modport sink   (input valid, operation, key, rank, output ready);
endinterface

interface tss_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] value_out;
  logic [9:0]         rank_out;
  logic [9:0]         member_count;
  modport source (output valid, status, value_out, rank_out, member_count, input ready);
  modport sink   (input valid, status, value_out, rank_out, member_count, output ready);
endinterface

// ----- sv/tss_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_store
// The three tier memories, one write and one registered read port each.
// Narrow and middle entries are stored at their width and sign-extended.
// ----------------------------------------------------------------------------
module tss_store
  import tss_pkg::*;
(
  input  logic                clk,
  input  mem_req_t            req_n,
  input  mem_req_t            req_m,
  input  mem_req_t            req_w,
  output logic signed [63:0]  rdata_n,
  output logic signed [63:0]  rdata_m,
  output logic signed [63:0]  rdata_w
);

  logic signed [15:0] narrow_mem [NARROW_DEPTH];
  logic signed [31:0] middle_mem [MIDDLE_DEPTH];
  logic signed [63:0] wide_mem   [WIDE_DEPTH];
  logic signed [15:0] rn_r;
  logic signed [31:0] rm_r;
  logic signed [63:0] rw_r;

  always_ff @(posedge clk) begin
    if (req_n.wr) narrow_mem[req_n.waddr] <= req_n.wdata[15:0];
    if (req_n.rd) rn_r <= narrow_mem[req_n.raddr];
  end

  always_ff @(posedge clk) begin
    if (req_m.wr) middle_mem[req_m.waddr] <= req_m.wdata[31:0];
    if (req_m.rd) rm_r <= middle_mem[req_m.raddr];
  end

  always_ff @(posedge clk) begin
    if (req_w.wr) wide_mem[req_w.waddr] <= req_w.wdata;
    if (req_w.rd) rw_r <= wide_mem[req_w.raddr];
  end

  assign rdata_n = 64'(rn_r);
  assign rdata_m = 64'(rm_r);
  assign rdata_w = rw_r;

endmodule

// ----- sv/tss_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: binary search, shift by read/write back, three-way merge.
// ----------------------------------------------------------------------------
module tss_ctrl
  import tss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  tss_in_if.sink             in_ch,
  tss_out_if.source          out_ch,
  output mem_req_t           req_n,
  output mem_req_t           req_m,
  output mem_req_t           req_w,
  input  logic signed [63:0] rdata_n,
  input  logic signed [63:0] rdata_m,
  input  logic signed [63:0] rdata_w,
  output logic               busy
);

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic signed [63:0] key_r, key_nxt;
  logic [TOT_W-1:0]   rank_r, rank_nxt;
  tier_t              tier_r, tier_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic               hit_r, hit_nxt;
  logic               any_r, any_nxt;
  logic [TOT_W-1:0]   racc_r, racc_nxt;
  logic [CNT_W-1:0]   sh_r, sh_nxt;      // shift cursor
  logic signed [63:0] hold_r, hold_nxt;  // value in flight during shift
  logic [CNT_W-1:0]   cnt_r [NUM_TIERS];
  logic [CNT_W-1:0]   cnt_nxt [NUM_TIERS];
  logic [CNT_W-1:0]   it_r [NUM_TIERS];
  logic [CNT_W-1:0]   it_nxt [NUM_TIERS];
  logic [CNT_W-1:0]   mp_r [NUM_TIERS];
  logic [CNT_W-1:0]   mp_nxt [NUM_TIERS];
  logic [TOT_W-1:0]   step_r, step_nxt;  // merge picks done
  result_t            res_r, res_nxt;
  logic               ovalid_r, ovalid_nxt;

  logic [CNT_W-1:0]   mid;
  logic signed [63:0] rsel;
  logic [CNT_W-1:0]   tcnt;
  logic [TOT_W-1:0]   total;
  logic [1:0]         best;
  logic               found;
  logic signed [63:0] bv;
  logic               mv [NUM_TIERS];
  logic signed [63:0] mval [NUM_TIERS];
  mem_req_t           rq [NUM_TIERS];

  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign tcnt  = cnt_r[tier_r];
  assign total = TOT_W'(cnt_r[0]) + TOT_W'(cnt_r[1]) + TOT_W'(cnt_r[2]);
  assign mval[0] = rdata_n;
  assign mval[1] = rdata_m;
  assign mval[2] = rdata_w;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    unique case (tier_r)
      TIER_NARROW: rsel = rdata_n;
      TIER_MIDDLE: rsel = rdata_m;
      default:     rsel = rdata_w;
    endcase
  end

  // Smallest live head among the three tiers.
  always_comb begin
    best  = 2'd0;
    found = 1'b0;
    bv    = KEY_MAX;
    for (int t = 0; t < NUM_TIERS; t++) begin
      mv[t] = mp_r[t] < cnt_r[t];
      if (mv[t] && (!found || mval[t] < bv)) begin
        best  = 2'(t);
        bv    = mval[t];
        found = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; key_nxt = key_r; rank_nxt = rank_r; tier_nxt = tier_r;
    lo_nxt = lo_r; hi_nxt = hi_r; hit_nxt = hit_r; any_nxt = any_r;
    racc_nxt = racc_r; sh_nxt = sh_r; hold_nxt = hold_r;
    step_nxt = step_r; res_nxt = res_r; ovalid_nxt = ovalid_r;
    for (int t = 0; t < NUM_TIERS; t++) begin
      cnt_nxt[t] = cnt_r[t];
      it_nxt[t]  = it_r[t];
      mp_nxt[t]  = mp_r[t];
      rq[t] = '0;
    end
    in_ch.ready = 1'b0;

    if (out_ch.ready) ovalid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = !ovalid_r || out_ch.ready;
        if (in_ch.valid && in_ch.ready) begin
          op_nxt   = op_t'(in_ch.operation);
          key_nxt  = in_ch.key;
          rank_nxt = in_ch.rank;
          res_nxt  = '0;
          any_nxt  = 1'b0;
          racc_nxt = '0;
          step_nxt = '0;
          unique case (op_t'(in_ch.operation))
            OP_INSERT, OP_REMOVE: begin
              tier_nxt  = tier_of(in_ch.key);
              lo_nxt    = '0;
              hi_nxt    = cnt_r[tier_of(in_ch.key)];
              state_nxt = S_SRCH_RD;
            end
            OP_FIND: begin
              tier_nxt  = TIER_NARROW;
              lo_nxt    = '0;
              hi_nxt    = cnt_r[0];
              state_nxt = S_SRCH_RD;
            end
            OP_GET: begin
              if (in_ch.rank >= total) begin
                res_nxt.status = ST_MISS;
                state_nxt = S_OUT;
              end else begin
                for (int t = 0; t < NUM_TIERS; t++) mp_nxt[t] = '0;
                state_nxt = S_MERGE_RD;
              end
            end
            OP_RESTART: begin
              for (int t = 0; t < NUM_TIERS; t++) it_nxt[t] = '0;
              state_nxt = S_OUT;
            end
            OP_NEXT: begin
              for (int t = 0; t < NUM_TIERS; t++) mp_nxt[t] = it_r[t];
              state_nxt = S_MERGE_RD;
            end
            default: begin
              res_nxt.status = ST_MISS;
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          rq[tier_r].rd    = 1'b1;
          rq[tier_r].raddr = mid[IDX_W-1:0];
          state_nxt = S_SRCH_CMP;
        end else if (lo_r < tcnt) begin
          rq[tier_r].rd    = 1'b1;
          rq[tier_r].raddr = lo_r[IDX_W-1:0];
          state_nxt = S_HIT_RD;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_DECIDE;
        end
      end

      S_SRCH_CMP: begin
        if (rsel < key_r) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = S_SRCH_RD;
      end

      S_HIT_RD: begin
        hit_nxt   = (rsel == key_r);
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        unique case (op_r)
          OP_FIND: begin
            racc_nxt = racc_r + TOT_W'(lo_r);
            if (hit_r) any_nxt = 1'b1;
            if (tier_r == TIER_WIDE) begin
              res_nxt.status   = (any_r || hit_r) ? ST_OK : ST_MISS;
              res_nxt.rank_out = racc_r + TOT_W'(lo_r);
              state_nxt = S_OUT;
            end else begin
              tier_nxt  = tier_t'(tier_r + 2'd1);
              lo_nxt    = '0;
              hi_nxt    = cnt_r[tier_r + 2'd1];
              state_nxt = S_SRCH_RD;
            end
          end
          OP_INSERT: begin
            if (hit_r) begin
              res_nxt.status = ST_MISS;
              state_nxt = S_OUT;
            end else if (tcnt[CNT_W-1]) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_OUT;
            end else begin
              // Walk up from pos, carrying each displaced entry.
              hold_nxt  = key_r;
              sh_nxt    = lo_r;
              state_nxt = S_SHIFT_RD;
            end
          end
          default: begin
            if (!hit_r) begin
              res_nxt.status = ST_MISS;
              state_nxt = S_OUT;
            end else begin
              sh_nxt    = lo_r;
              state_nxt = S_SHIFT_RD;
            end
          end
        endcase
      end

      S_SHIFT_RD: begin
        if (op_r == OP_INSERT) begin
          if (sh_r == tcnt) begin
            rq[tier_r].wr    = 1'b1;
            rq[tier_r].waddr = sh_r[IDX_W-1:0];
            rq[tier_r].wdata = hold_r;
            cnt_nxt[tier_r]  = tcnt + 1'b1;
            state_nxt = S_OUT;
          end else begin
            rq[tier_r].rd    = 1'b1;
            rq[tier_r].raddr = sh_r[IDX_W-1:0];
            state_nxt = S_SHIFT_WR;
          end
        end else begin
          if (sh_r + 1'b1 >= tcnt) begin
            cnt_nxt[tier_r] = tcnt - 1'b1;
            state_nxt = S_OUT;
          end else begin
            rq[tier_r].rd    = 1'b1;
            rq[tier_r].raddr = IDX_W'(sh_r + 1'b1);
            state_nxt = S_SHIFT_WR;
          end
        end
      end

      S_SHIFT_WR: begin
        rq[tier_r].wr    = 1'b1;
        rq[tier_r].waddr = sh_r[IDX_W-1:0];
        if (op_r == OP_INSERT) begin
          rq[tier_r].wdata = hold_r;
          hold_nxt = rsel;
        end else begin
          rq[tier_r].wdata = rsel;
        end
        sh_nxt    = sh_r + 1'b1;
        state_nxt = S_SHIFT_RD;
      end

      S_MERGE_RD: begin
        for (int t = 0; t < NUM_TIERS; t++) begin
          rq[t].rd    = 1'b1;
          rq[t].raddr = mp_r[t][IDX_W-1:0];
        end
        state_nxt = S_MERGE_CMP;
      end

      S_MERGE_CMP: begin
        if (op_r == OP_NEXT) begin
          if (found) begin
            it_nxt[best]      = it_r[best] + 1'b1;
            res_nxt.value_out = bv;
          end else begin
            res_nxt.status = ST_MISS;
          end
          state_nxt = S_OUT;
        end else begin
          // rank < total, so a pick always exists here
          mp_nxt[best] = mp_r[best] + 1'b1;
          if (step_r == rank_r) begin
            res_nxt.value_out = bv;
            state_nxt = S_OUT;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = S_MERGE_RD;
          end
        end
      end

      S_OUT: begin
        res_nxt.member_count = total;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign req_n = rq[0];
  assign req_m = rq[1];
  assign req_w = rq[2];

  assign out_ch.valid        = ovalid_r;
  assign out_ch.status       = res_r.status;
  assign out_ch.value_out    = res_r.value_out;
  assign out_ch.rank_out     = res_r.rank_out;
  assign out_ch.member_count = res_r.member_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      for (int t = 0; t < NUM_TIERS; t++) begin
        cnt_r[t] <= '0;
        it_r[t]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      for (int t = 0; t < NUM_TIERS; t++) begin
        cnt_r[t] <= cnt_nxt[t];
        it_r[t]  <= it_nxt[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; key_r <= key_nxt; rank_r <= rank_nxt; tier_r <= tier_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; hit_r <= hit_nxt; any_r <= any_nxt;
    racc_r <= racc_nxt; sh_r <= sh_nxt; hold_r <= hold_nxt;
    step_r <= step_nxt; res_r <= res_nxt;
    for (int t = 0; t < NUM_TIERS; t++) mp_r[t] <= mp_nxt[t];
  end

endmodule

// ----- sv/tiered_sorted_integer_set_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_sorted_integer_set_core
// Set of distinct signed 64-bit integers kept in three sorted tier memories.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// in_     | in  | operation[2:0], key[63:0], rank[9:0]
// out_    | out | status[1:0], value_out[63:0], rank_out[9:0], member_count[9:0]
//
// One operation at a time. Find runs a binary search in each tier in turn,
// insert and remove a search plus a read and a write per shifted entry,
// get a merge over rank+1 picks, iterator next a single merge pick.
// No clearing pass after reset: only state, output valid, counts and cursors reset.
// The result register frees the input side once the result is taken.
module tiered_sorted_integer_set_core
  import tss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tss_in_if.sink    in_ch,
  tss_out_if.source out_ch
);

  mem_req_t           req_n, req_m, req_w;
  logic signed [63:0] rdata_n, rdata_m, rdata_w;
  logic               busy;

  tss_store u_store (
    .clk, .req_n, .req_m, .req_w, .rdata_n, .rdata_m, .rdata_w
  );

  tss_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .out_ch, .req_n, .req_m, .req_w,
    .rdata_n, .rdata_m, .rdata_w, .busy
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready) else $error("input taken while busy");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status != 2'd3) else $error("bad status");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.member_count <= 10'd768) else $error("count overflow");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> busy) else $error("accepted item not started");
`endif

endmodule

// ----- dv/tb_tiered_sorted_integer_set_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiered_sorted_integer_set_core
// Self-checking bench for the tiered sorted integer set. A short table of
// directed operations is followed by random operations and a tier fill. Every
// result is compared with a behavioral model of the three sorted tiers, or with
// the result a typed directed row gives, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_tiered_sorted_integer_set_core;
  import tss_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         STALL_LIMIT = 40000;
  localparam int         LONG_HOLD   = 3000;
  localparam int         DRAIN_CYCLES = 2000;
  localparam logic signed [63:0] KEY_MIN = ~KEY_MAX;

  typedef struct {
    logic [2:0]         op;
    logic signed [63:0] key;
    logic [9:0]         rank;
    bit                 typed;
    result_t            res;
  } vector_t;

  logic clk;
  logic rst_n;

  tss_in_if  in_ch();
  tss_out_if out_ch();

  tiered_sorted_integer_set_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Set model: three sorted tiers, member counts and iterator cursors.
  logic signed [63:0] tier_mem [3][256];
  int                 tier_cnt [3];
  int                 cursor   [3];
  int                 tier_cap [3];

  result_t result_q[$];
  int      mismatches;
  int      checked;
  int      sent;
  int      op_seen [8];
  int      src_pct;
  int      snk_pct;
  bit      hold_req;
  int      hold_left;
  int      quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int band_of(input logic signed [63:0] k);
    if ($signed(k[15:0]) == k) return 0;
    if ($signed(k[31:0]) == k) return 1;
    return 2;
  endfunction

  function automatic int lower_bound(input int t, input logic signed [63:0] k);
    int i;
    for (i = 0; i < tier_cnt[t]; i++)
      if (tier_mem[t][i] >= k) return i;
    return tier_cnt[t];
  endfunction

  // Smallest head among tiers whose cursor is below the count; -1 when none.
  function automatic int head_pick(input int p[3], output logic signed [63:0] v);
    int t;
    int best;
    best = -1;
    v = '0;
    for (t = 0; t < 3; t++)
      if (p[t] < tier_cnt[t] && (best < 0 || tier_mem[t][p[t]] < v)) begin
        best = t;
        v = tier_mem[t][p[t]];
      end
    return best;
  endfunction

  function automatic result_t apply_op(input logic [2:0] op, input logic signed [63:0] k,
                                       input logic [9:0] r);
    result_t            res;
    int                 b;
    int                 pos;
    int                 i;
    int                 t;
    bit                 hit;
    logic signed [63:0] v;
    int                 p[3];
    res = '0;
    res.status = ST_OK;
    b = band_of(k);
    pos = lower_bound(b, k);
    hit = pos < tier_cnt[b] && tier_mem[b][pos] == k;
    case (op)
      OP_INSERT: begin
        if (hit) res.status = ST_MISS;
        else if (tier_cnt[b] >= tier_cap[b]) res.status = ST_FULL;
        else begin
          for (i = tier_cnt[b]; i > pos; i--) tier_mem[b][i] = tier_mem[b][i-1];
          tier_mem[b][pos] = k;
          tier_cnt[b]++;
        end
      end
      OP_REMOVE: begin
        if (!hit) res.status = ST_MISS;
        else begin
          for (i = pos; i < tier_cnt[b] - 1; i++) tier_mem[b][i] = tier_mem[b][i+1];
          tier_cnt[b]--;
        end
      end
      OP_FIND: begin
        res.rank_out = 10'(lower_bound(0, k) + lower_bound(1, k) + lower_bound(2, k));
        if (!hit) res.status = ST_MISS;
      end
      OP_GET: begin
        if (int'(r) >= tier_cnt[0] + tier_cnt[1] + tier_cnt[2]) res.status = ST_MISS;
        else begin
          p = '{0, 0, 0};
          for (i = 0; i <= int'(r); i++) begin
            t = head_pick(p, v);
            p[t]++;
          end
          res.value_out = v;
        end
      end
      OP_RESTART: cursor = '{0, 0, 0};
      OP_NEXT: begin
        t = head_pick(cursor, v);
        if (t < 0) res.status = ST_MISS;
        else begin
          res.value_out = v;
          cursor[t]++;
        end
      end
      default: res.status = ST_MISS;
    endcase
    res.member_count = 10'(tier_cnt[0] + tier_cnt[1] + tier_cnt[2]);
    return res;
  endfunction

  function automatic result_t typed_res(input logic [1:0] st, input logic signed [63:0] v,
                                        input logic [9:0] ro, input logic [9:0] mc);
    result_t res;
    res.status = st;
    res.value_out = v;
    res.rank_out = ro;
    res.member_count = mc;
    return res;
  endfunction

  // Offer one operation; starts and ends on a falling edge.
  task automatic offer(input logic [2:0] op, input logic signed [63:0] k,
                       input logic [9:0] r, input bit typed, input result_t tres);
    result_t pred;
    if ($urandom_range(99) < src_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= k;
    in_ch.rank      <= r;
    do @(posedge clk); while (!in_ch.ready);
    pred = apply_op(op, k, r);
    result_q.push_back(typed ? tres : pred);
    sent++;
    op_seen[op]++;
    @(negedge clk);
  endtask

  function automatic logic signed [63:0] pick_key(input int cls);
    logic signed [63:0] k;
    int                 t;
    case (cls)
      0: k = 64'($signed(16'($urandom)));
      1: k = 64'($signed($urandom));
      2: k = {$urandom, $urandom};
      3: begin
        case ($urandom_range(7))
          0: k = -64'sd32768;
          1: k = 64'sd32767;
          2: k = -64'sd32769;
          3: k = 64'sd32768;
          4: k = 64'($signed(32'h8000_0000));
          5: k = 64'sd2147483647;
          6: k = KEY_MAX;
          default: k = KEY_MIN;
        endcase
      end
      default: begin
        t = $urandom_range(2);
        if (tier_cnt[t] == 0) k = 64'($signed(16'($urandom)));
        else k = tier_mem[t][$urandom_range(tier_cnt[t] - 1)];
      end
    endcase
    return k;
  endfunction

  task automatic random_items(input int n);
    int                 i;
    int                 w;
    logic [2:0]         op;
    logic [9:0]         r;
    logic signed [63:0] k;
    int                 total;
    for (i = 0; i < n; i++) begin
      w = $urandom_range(99);
      if (w < 30) op = OP_INSERT;
      else if (w < 45) op = OP_REMOVE;
      else if (w < 62) op = OP_FIND;
      else if (w < 75) op = OP_GET;
      else if (w < 80) op = OP_RESTART;
      else if (w < 97) op = OP_NEXT;
      else op = ($urandom_range(1)) ? OP_SPARE_LO : OP_SPARE_HI;
      w = $urandom_range(99);
      k = pick_key(w < 30 ? 0 : w < 45 ? 1 : w < 60 ? 2 : w < 67 ? 3 : 4);
      total = tier_cnt[0] + tier_cnt[1] + tier_cnt[2];
      if ($urandom_range(9) == 0) r = 10'($urandom);
      else r = 10'($urandom_range(total + 1));
      offer(op, k, r, 1'b0, '0);
    end
  endtask

  // Receiver: random ready, or a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= snk_pct);
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        automatic result_t e = result_q.pop_front();
        checked++;
        if (out_ch.status !== e.status || out_ch.value_out !== e.value_out ||
            out_ch.rank_out !== e.rank_out || out_ch.member_count !== e.member_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch #%0d: exp st=%0d val=%0d rank=%0d cnt=%0d,",
                      " got st=%0d val=%0d rank=%0d cnt=%0d"},
                     checked, e.status, e.value_out, e.rank_out, e.member_count,
                     out_ch.status, out_ch.value_out, out_ch.rank_out,
                     out_ch.member_count);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    vector_t            dir [$];
    int                 i;
    logic signed [63:0] k;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.key       = '0;
    in_ch.rank      = '0;
    out_ch.ready    = 1'b0;
    hold_req        = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    mismatches      = 0;
    checked         = 0;
    sent            = 0;
    op_seen         = '{default: 0};
    tier_cnt        = '{0, 0, 0};
    cursor          = '{0, 0, 0};
    tier_cap        = '{NARROW_DEPTH, MIDDLE_DEPTH, WIDE_DEPTH};
    src_pct         = 25;
    snk_pct         = 73;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table; typed rows carry the result that is known up front.
    dir = '{
      '{OP_FIND,     64'sd5,          10'd0, 1, typed_res(ST_MISS, 0, 0, 0)},
      '{OP_NEXT,     64'sd0,          10'd0, 1, typed_res(ST_MISS, 0, 0, 0)},
      '{OP_GET,      64'sd0,          10'd0, 1, typed_res(ST_MISS, 0, 0, 0)},
      '{OP_REMOVE,   64'sd7,          10'd0, 1, typed_res(ST_MISS, 0, 0, 0)},
      '{OP_INSERT,   KEY_MAX,         10'd0, 1, typed_res(ST_OK, 0, 0, 1)},
      '{OP_INSERT,   KEY_MIN,         10'd0, 1, typed_res(ST_OK, 0, 0, 2)},
      '{OP_INSERT,   KEY_MAX,         10'd0, 1, typed_res(ST_MISS, 0, 0, 2)},
      '{OP_GET,      64'sd0,          10'd0, 1, typed_res(ST_OK, KEY_MIN, 0, 2)},
      '{OP_GET,      64'sd0,          10'd1, 1, typed_res(ST_OK, KEY_MAX, 0, 2)},
      '{OP_GET,      64'sd0,          10'd1023, 1, typed_res(ST_MISS, 0, 0, 2)},
      '{OP_INSERT,   -64'sd32768,     10'd0, 0, '0},
      '{OP_INSERT,   64'sd32767,      10'd0, 0, '0},
      '{OP_INSERT,   64'sd32768,      10'd0, 0, '0},
      '{OP_INSERT,   -64'sd32769,     10'd0, 0, '0},
      '{OP_INSERT,   64'sd2147483647, 10'd0, 0, '0},
      '{OP_INSERT,   64'sh0000_0000_8000_0000, 10'd0, 0, '0},
      '{OP_FIND,     64'sd32768,      10'd0, 0, '0},
      '{OP_FIND,     64'sd1,          10'd0, 0, '0},
      '{OP_NEXT,     64'sd0,          10'd0, 0, '0},
      '{OP_NEXT,     64'sd0,          10'd0, 0, '0},
      '{OP_REMOVE,   64'sd32767,      10'd0, 0, '0},
      '{OP_NEXT,     64'sd0,          10'd0, 0, '0},
      '{OP_RESTART,  64'sd0,          10'd0, 0, '0},
      '{OP_SPARE_LO, 64'sd0,          10'd0, 0, '0},
      '{OP_SPARE_HI, -64'sd1,         10'd1023, 0, '0}
    };
    @(negedge clk);
    foreach (dir[i]) offer(dir[i].op, dir[i].key, dir[i].rank, dir[i].typed, dir[i].res);

    // Stall the result side long enough to back up the input.
    hold_req = 1'b1;
    random_items(180);

    // Pause until every result is back, then fill the middle tier past full.
    in_ch.valid <= 1'b0;
    wait (result_q.size() == 0);
    @(negedge clk);
    src_pct = 73;
    snk_pct = 25;
    while (tier_cnt[1] < MIDDLE_DEPTH) begin
      do k = 64'($signed($urandom)); while (band_of(k) != 1);
      offer(OP_INSERT, k, 10'd0, 1'b0, '0);
    end
    for (i = 0; i < 4; i++) begin
      do k = 64'($signed($urandom)); while (band_of(k) != 1);
      offer(OP_INSERT, k, 10'd0, 1'b0, '0);
    end
    random_items(170);

    src_pct = 0;
    snk_pct = 0;
    random_items(180);

    in_ch.valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d operations: %0d insert, %0d remove, %0d find, %0d get, %0d next",
             sent, op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_FIND],
             op_seen[OP_GET], op_seen[OP_NEXT]);
    $display("checked %0d results, %0d mismatches, middle tier filled to capacity",
             checked, mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
